// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CBAS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// A condition that, when seen, must be followed by another in the next cycle.
`define CBAS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/cbas_pkg.sv -----
`default_nettype none
package cbas_pkg;

  // Field and register widths.
  localparam int CFG_W   = 12;
  localparam int S_W     = 4;
  localparam int SAMP_W  = 8;
  localparam int AVG_W   = 16;
  localparam int BLK_W   = 11;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int MAX_FACTOR    = 8;

  localparam int FW     = $clog2(MAX_FACTOR);
  localparam int PART_W = $clog2(MAX_FACTOR * 255 + 1);
  localparam int SUM_W  = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
  localparam int AREA_W = 2 * S_W;
  localparam int NUM_W  = SUM_W + 8;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_FACTOR = 2;

  // Output queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Reciprocals of the block area, ceil(2^K / area). K is large enough that
  // the truncated product equals the exact floor quotient for every numerator.
  localparam int RECIP_K = 30;
  localparam int RECIP_W = RECIP_K + 1;
  localparam longint ONE_K = longint'(1) << RECIP_K;

  typedef logic [RECIP_W-1:0] recip_t;

  localparam recip_t RECIP_TBL [0:(1 << S_W) - 1] = '{
    recip_t'(ONE_K),
    recip_t'(ONE_K),
    recip_t'((ONE_K + 3) / 4),
    recip_t'((ONE_K + 8) / 9),
    recip_t'((ONE_K + 15) / 16),
    recip_t'((ONE_K + 24) / 25),
    recip_t'((ONE_K + 35) / 36),
    recip_t'((ONE_K + 48) / 49),
    recip_t'((ONE_K + 63) / 64),
    recip_t'((ONE_K + 63) / 64),
    recip_t'((ONE_K + 63) / 64),
    recip_t'((ONE_K + 63) / 64),
    recip_t'((ONE_K + 63) / 64),
    recip_t'((ONE_K + 63) / 64),
    recip_t'((ONE_K + 63) / 64),
    recip_t'((ONE_K + 63) / 64)
  };

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FACTOR = 2'd2
  } reg_idx_e;

  // Coordinates and frame mark that travel with a block sum.
  typedef struct packed {
    logic [BLK_W-1:0] col;
    logic [BLK_W-1:0] row;
    logic             fend;
  } blk_tag_t;

endpackage
`default_nettype wire

// ----- rtl/cbas_ram.sv -----
`default_nettype none
module cbas_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cbas_scaler.sv -----
`default_nettype none
module cbas_scaler import cbas_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [SUM_W-1:0] sum_i,
  input  wire logic [S_W-1:0]   factor_i,
  input  wire blk_tag_t         tag_i,
  output logic                  out_valid_o,
  output logic [AVG_W-1:0]      avg_o,
  output blk_tag_t              tag_o,
  output logic [1:0]            pending_o
);

  // First stage forms sum*256 + area/2 and looks up the reciprocal.
  logic [AREA_W-1:0]          area;
  logic [NUM_W-1:0]           num_d, num_q;
  recip_t                     recip_q;
  blk_tag_t                   tag_a_q;
  logic                       val_a_q;
  logic [NUM_W+RECIP_W-1:0]   prod;

  always_comb begin
    area  = AREA_W'(factor_i) * AREA_W'(factor_i);
    num_d = {sum_i, 8'h00} + NUM_W'(area >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_a_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      val_a_q     <= in_valid_i;
      out_valid_o <= val_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      num_q   <= num_d;
      recip_q <= RECIP_TBL[factor_i];
      tag_a_q <= tag_i;
    end
  end

  // Second stage: one multiply, the quotient is the upper part of the product.
  assign prod = (NUM_W+RECIP_W)'(num_q) * (NUM_W+RECIP_W)'(recip_q);

  always_ff @(posedge clk_i) begin
    if (val_a_q) begin
      avg_o <= prod[RECIP_K +: AVG_W];
      tag_o <= tag_a_q;
    end
  end

  assign pending_o = {1'b0, val_a_q} + {1'b0, out_valid_o};

endmodule
`default_nettype wire

// ----- rtl/chroma_block_average_subsampler.sv -----
// Chroma block average subsampler.
// Samples arrive on sample_i, one per item, in raster order with x fastest,
// under in_valid_i / in_ready_o. Each completed SxS block gives one item on
// block_average_o (unsigned Q8.8, rounded half up), block_col_o, block_row_o
// and frame_end_o under out_valid_o / out_ready_i.
// Configuration uses an APB-style port: width at 0x0, height at 0x4, block
// factor at 0x8. Any of these writes restarts the frame at the next sample.
// Throughput is one sample per cycle while in_ready_o is high. A block result
// goes from the read and write back of the column sum memory through the
// registered reciprocal multiply into the output queue.
// Results go into an eight-deep output queue; when the queue plus the
// results still in flight reach eight, in_ready_o drops, so a stalled
// receiver holds the input side back without losing anything.
// After reset the registers hold 640x480 with a block factor of two and the
// position counters are zero. The sum memory needs no clearing pass: the
// first row of each block in a band reloads the sum instead of adding.
`default_nettype none
`include "assert_macros.svh"
module chroma_block_average_subsampler import cbas_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [SAMP_W-1:0] sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [AVG_W-1:0]  block_average_o,
  output logic      [BLK_W-1:0]  block_col_o,
  output logic      [BLK_W-1:0]  block_row_o,
  output logic                   frame_end_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WLIM_I = (MAX_WIDTH < (1 << CFG_W) - 1) ? MAX_WIDTH : (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] W_LIM = CFG_W'(WLIM_I);
  localparam logic [CFG_W-1:0] H_LIM = CFG_W'(MAX_HEIGHT);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] width_q, height_q;
  logic [S_W-1:0]   factor_q;
  logic             cfg_we, restart;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    unique case (cfg_idx)
      REG_WIDTH: begin
        restart = cfg_we;
        prdata  = APB_DW'(width_q);
      end
      REG_HEIGHT: begin
        restart = cfg_we;
        prdata  = APB_DW'(height_q);
      end
      REG_FACTOR: begin
        restart = cfg_we;
        prdata  = APB_DW'(factor_q);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(RESET_WIDTH);
      height_q <= CFG_W'(RESET_HEIGHT);
      factor_q <= S_W'(RESET_FACTOR);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        REG_FACTOR: factor_q <= pwdata[S_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective geometry: zero reads as one, large values saturate.
  logic [S_W-1:0]   s_eff;
  logic [FW-1:0]    sm1;
  logic [CFG_W-1:0] w_eff, h_eff;

  always_comb begin
    priority if (factor_q == '0) begin
      s_eff = S_W'(1);
    end else if (factor_q > S_W'(MAX_FACTOR)) begin
      s_eff = S_W'(MAX_FACTOR);
    end else begin
      s_eff = factor_q;
    end
    priority if (width_q == '0) begin
      w_eff = CFG_W'(1);
    end else if (width_q > W_LIM) begin
      w_eff = W_LIM;
    end else begin
      w_eff = width_q;
    end
    priority if (height_q == '0) begin
      h_eff = CFG_W'(1);
    end else if (height_q > H_LIM) begin
      h_eff = H_LIM;
    end else begin
      h_eff = height_q;
    end
  end

  assign sm1 = FW'(s_eff - S_W'(1));

  // ---------------------------------------------------------------------
  // Position tracking and row partial sums (accept stage)
  // ---------------------------------------------------------------------
  // bx_q/by_q hold the first pixel of the current block, so the fit tests
  // are plain add-and-compare and no division by S is needed.
  logic [CFG_W-1:0]  px_q, py_q, bx_q, by_q;
  logic [AW-1:0]     bc_q;
  logic [BLK_W-1:0]  br_q;
  logic [FW-1:0]     cib_q, rib_q;
  logic [PART_W-1:0] part_q, part_d;

  logic accept, col_fit, row_fit, last_col, last_row, cib_end, rib_end;
  logic x_last, y_last, touch;

  assign accept   = in_valid_i & in_ready_o;
  assign col_fit  = ({1'b0, bx_q} + (CFG_W+1)'(s_eff)) <= {1'b0, w_eff};
  assign row_fit  = ({1'b0, by_q} + (CFG_W+1)'(s_eff)) <= {1'b0, h_eff};
  assign last_col = ({1'b0, bx_q} + (CFG_W+1)'({s_eff, 1'b0})) > {1'b0, w_eff};
  assign last_row = ({1'b0, by_q} + (CFG_W+1)'({s_eff, 1'b0})) > {1'b0, h_eff};
  assign cib_end  = (cib_q == sm1);
  assign rib_end  = (rib_q == sm1);
  assign x_last   = (px_q == w_eff - CFG_W'(1));
  assign y_last   = (py_q == h_eff - CFG_W'(1));
  // A row of one block is complete: fold it into the column sum.
  assign touch    = accept & col_fit & row_fit & cib_end;

  assign part_d = ((cib_q == '0) ? '0 : part_q) + PART_W'(sample_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q  <= '0;
      py_q  <= '0;
      bx_q  <= '0;
      by_q  <= '0;
      bc_q  <= '0;
      br_q  <= '0;
      cib_q <= '0;
      rib_q <= '0;
    end else if (restart) begin
      px_q  <= '0;
      py_q  <= '0;
      bx_q  <= '0;
      by_q  <= '0;
      bc_q  <= '0;
      br_q  <= '0;
      cib_q <= '0;
      rib_q <= '0;
    end else if (accept) begin
      if (x_last) begin
        px_q  <= '0;
        bx_q  <= '0;
        bc_q  <= '0;
        cib_q <= '0;
        if (y_last) begin
          py_q  <= '0;
          by_q  <= '0;
          br_q  <= '0;
          rib_q <= '0;
        end else begin
          py_q <= py_q + CFG_W'(1);
          if (rib_end) begin
            rib_q <= '0;
            br_q  <= br_q + BLK_W'(1);
            by_q  <= by_q + CFG_W'(s_eff);
          end else begin
            rib_q <= rib_q + FW'(1);
          end
        end
      end else begin
        px_q <= px_q + CFG_W'(1);
        if (cib_end) begin
          cib_q <= '0;
          bc_q  <= bc_q + AW'(1);
          bx_q  <= bx_q + CFG_W'(s_eff);
        end else begin
          cib_q <= cib_q + FW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Column sum memory: read at the accept stage, add and write back in the
  // next cycle. A read of the entry being written in that same cycle takes
  // the new sum from the forwarding register instead of the memory output.
  // ---------------------------------------------------------------------
  logic              s1_valid_q, s1_emit_q, s1_first_q;
  logic [AW-1:0]     s1_addr_q;
  logic [PART_W-1:0] s1_part_q;
  blk_tag_t          s1_tag_q;
  logic              fwd_q;
  logic [SUM_W-1:0]  fwd_data_q, ram_rdata, base1, sum1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= touch;
      s1_emit_q  <= touch & rib_end;
      fwd_q      <= touch & s1_valid_q & (bc_q == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (touch) begin
      s1_first_q   <= (rib_q == '0);
      s1_addr_q    <= bc_q;
      s1_part_q    <= part_d;
      s1_tag_q.col <= BLK_W'(bc_q);
      s1_tag_q.row <= br_q;
      s1_tag_q.fend <= last_col & last_row;
    end
    fwd_data_q <= sum1;
  end

  always_comb begin
    priority if (s1_first_q) begin
      base1 = '0;
    end else if (fwd_q) begin
      base1 = fwd_data_q;
    end else begin
      base1 = ram_rdata;
    end
    sum1 = base1 + SUM_W'(s1_part_q);
  end

  cbas_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (sum1),
    .re_i    (touch),
    .raddr_i (bc_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Division by the block area through a reciprocal multiply.
  // ---------------------------------------------------------------------
  logic             sc_valid;
  logic [AVG_W-1:0] sc_avg;
  blk_tag_t         sc_tag;
  logic [1:0]       sc_pending;

  cbas_scaler u_scaler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q & s1_emit_q),
    .sum_i       (sum1),
    .factor_i    (s_eff),
    .tag_i       (s1_tag_q),
    .out_valid_o (sc_valid),
    .avg_o       (sc_avg),
    .tag_o       (sc_tag),
    .pending_o   (sc_pending)
  );

  // ---------------------------------------------------------------------
  // Output queue. Input is taken only while every result that could still
  // arrive has a free slot waiting for it.
  // ---------------------------------------------------------------------
  logic [AVG_W-1:0]   fifo_avg_q [FIFO_DEPTH];
  blk_tag_t           fifo_tag_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] fifo_cnt_q, inflight;
  logic               fifo_pop;

  assign fifo_pop = out_valid_o & out_ready_i;
  assign inflight = fifo_cnt_q + FIFO_CW'(s1_valid_q & s1_emit_q) + FIFO_CW'(sc_pending);
  assign in_ready_o = (inflight < FIFO_CW'(FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (sc_valid) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(sc_valid) - FIFO_CW'(fifo_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_valid) begin
      fifo_avg_q[wr_ptr_q] <= sc_avg;
      fifo_tag_q[wr_ptr_q] <= sc_tag;
    end
  end

  assign out_valid_o     = (fifo_cnt_q != '0);
  assign block_average_o = fifo_avg_q[rd_ptr_q];
  assign block_col_o     = fifo_tag_q[rd_ptr_q].col;
  assign block_row_o     = fifo_tag_q[rd_ptr_q].row;
  assign frame_end_o     = fifo_tag_q[rd_ptr_q].fend;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `CBAS_ASSERT(a_fifo_no_overflow, clk_i, rst_ni,
    !(sc_valid && (fifo_cnt_q == FIFO_CW'(FIFO_DEPTH)) && !fifo_pop))
  `CBAS_ASSERT_NEXT(a_read_then_writeback, clk_i, rst_ni, touch, s1_valid_q)
  `CBAS_ASSERT(a_block_offsets_bound, clk_i, rst_ni, (cib_q <= sm1) && (rib_q <= sm1))
  `CBAS_ASSERT(a_average_range, clk_i, rst_ni, !out_valid_o || (block_average_o <= 16'hFF00))

endmodule
`default_nettype wire
